// File: hw/rtl/kwsm_pkg.sv
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared constants and types for the keyword signature matcher.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam int WINDOW_LEN_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CHAR_W       = 8;
    localparam int TOTAL_W      = 32;
    localparam int SIG_COUNT    = 6;
    localparam int SIG_MAX_LEN  = 32;
    localparam int SIG_LEN_W    = 6;

    // Lower-cased signatures, right-justified: the last character sits in bits [7:0].
    localparam logic [SIG_MAX_LEN*CHAR_W-1:0] SIG_TEXT [SIG_COUNT] = '{
        {"max_", "throttle"},
        "drop",
        "fuzz",
        "ignore all previous instructions",
        "system failure",
        "override"
    };

    localparam logic [SIG_LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
        6'd12, 6'd4, 6'd4, 6'd32, 6'd14, 6'd8
    };

    typedef logic [SIG_COUNT-1:0] sig_vec_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } hist_ctl_t;

    // Character expected k positions before the end of signature s.
    function automatic logic [CHAR_W-1:0] sig_byte(input int s, input int k);
        logic [CHAR_W-1:0] b;
        b = '0;
        if (k < SIG_MAX_LEN)
        begin
            b = SIG_TEXT[s][CHAR_W*k +: CHAR_W];
        end
        return b;
    endfunction

endpackage

// File: hw/rtl/keyword_signature_matcher_top.sv
// ----------------------------------------------------------------------------
// keyword_signature_matcher_top
// Scans command strings for fixed signatures and counts blocked commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command character per beat; tlast marks the final
//   character. A lone NUL with tlast set is an empty command.
//   m_axis carries one verdict beat per command, produced from the tlast beat:
//   verdict_safe (1 = no signature found) and the saturating blocked count.
// Throughput: one character per cycle unless stalled. The history is a row of byte
//   cells that shift every accepted beat but tlast, which clears them; all signature
//   comparators work in parallel on the window ending at the incoming character.
// Output: the verdict appears on m_axis in the cycle after the tlast beat.
// Stall: the verdict sits in an output register; while it waits with
//   m_axis_tready low, s_axis_tready is low and no character is taken.
//   With m_axis_tready high the next beat is taken in the same cycle.
// Reset: history cleared to zero bytes, match flag and count cleared,
//   no verdict pending. History and flag are also cleared after each verdict.
// ----------------------------------------------------------------------------
module keyword_signature_matcher_top
    import kwsm_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [0] verdict_safe, [32:1] blocked_total, pad
);

    localparam int NCELL = WINDOW_LEN - 1;
    localparam int OUT_W = 1 + TOTAL_W;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    logic [CHAR_W-1:0]      cur_char;
    logic                   beat_in;
    logic                   last_in;
    hist_ctl_t              ctl;
    logic [CHAR_W-1:0]      chain [NCELL+1];
    sig_vec_t               cell_hit [NCELL];
    sig_vec_t               sig_hit;
    logic                   any_hit;
    logic                   seen_now;

    logic                   match_seen_reg;
    logic                   match_seen_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;
    logic [COUNT_WIDTH+TOTAL_W-1:0] count_ext;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign beat_in       = s_axis_tvalid && s_axis_tready;
    assign last_in       = beat_in && s_axis_tlast;
    assign cur_char      = fold(s_axis_tdata);

    assign ctl.shift = beat_in && !s_axis_tlast;
    assign ctl.clear = last_in;

    assign chain[0] = cur_char;

    genvar c;
    generate
        for (c = 0; c < NCELL; c++)
        begin : g_cell
            kwsm_cell #(
                .POS (c + 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .byte_in  (chain[c]),
                .byte_out (chain[c+1]),
                .hit      (cell_hit[c])
            );
        end
    endgenerate

    always_comb
    begin
        for (int s = 0; s < SIG_COUNT; s++)
        begin
            sig_hit[s] = (cur_char == sig_byte(s, 0)) && (int'(SIG_LEN[s]) <= WINDOW_LEN);
            for (int k = 0; k < NCELL; k++)
            begin
                sig_hit[s] = sig_hit[s] & cell_hit[k][s];
            end
        end
    end

    assign any_hit  = |sig_hit;
    assign seen_now = match_seen_reg || any_hit;

    always_comb
    begin
        match_seen_next = match_seen_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (beat_in)
        begin
            if (s_axis_tlast)
            begin
                match_seen_next = 1'b0;
                if (seen_now && (count_reg != {COUNT_WIDTH{1'b1}}))
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
                out_valid_next = 1'b1;
                out_data_next  = {count_ext[TOTAL_W-1:0], !seen_now};
            end
            else
            begin
                match_seen_next = seen_now;
            end
        end
    end

    assign count_ext = {{TOTAL_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_seen_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            match_seen_reg <= match_seen_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(40 - OUT_W){1'b0}}, out_data_reg};

    // count never moves backward
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("blocked count decreased");

    // a command end clears the flag and the newest history byte
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        last_in |=> (!match_seen_reg && chain[1] == '0))
        else $error("state not cleared after verdict");

    // every command end yields a pending verdict
    a_end_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        last_in |=> out_valid_reg)
        else $error("verdict missing");

    // a blocked verdict implies a nonzero count
    a_blocked_count: assert property (@(posedge clk) disable iff (!rst_n)
        (last_in && seen_now) |=> (count_reg != '0))
        else $error("blocked verdict with zero count");

endmodule

// File: hw/rtl/kwsm_cell.sv
// ----------------------------------------------------------------------------
// kwsm_cell
// One history byte: shifts toward the older end and checks its byte
// against every signature at its own distance from the current character.
// ----------------------------------------------------------------------------
module kwsm_cell
    import kwsm_pkg::*;
#(
    parameter int POS = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hist_ctl_t         ctl,
    input  logic [CHAR_W-1:0] byte_in,
    output logic [CHAR_W-1:0] byte_out,
    output sig_vec_t          hit
);

    logic [CHAR_W-1:0] byte_reg;
    logic [CHAR_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.clear)
        begin
            byte_next = '0;
        end
        else if (ctl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

    // Positions beyond a signature's length always agree.
    genvar s;
    generate
        for (s = 0; s < SIG_COUNT; s++)
        begin : g_sig
            if (POS >= int'(SIG_LEN[s]))
            begin : g_free
                assign hit[s] = 1'b1;
            end
            else
            begin : g_cmp
                assign hit[s] = (byte_reg == sig_byte(s, POS));
            end
        end
    endgenerate

endmodule
